>>> src/ithp_pkg.sv
// ----------------------------------------------------------------------------
// IPv4/TCP header parser package
// Shared types, codes and constants for the byte-serial header parser.
// ----------------------------------------------------------------------------
package ithp_pkg;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_DROP    = 2'd2
	} kind_t;

	localparam logic [1:0] LINK_LOOPBACK = 2'd0;
	localparam logic [1:0] LINK_ETHERNET = 2'd1;
	localparam logic [1:0] LINK_NONE     = 2'd2;

	localparam logic [4:0] LOOPBACK_HDR_BYTES = 5'd4;
	localparam logic [4:0] ETHERNET_HDR_BYTES = 5'd14;
	localparam logic [5:0] MIN_HDR_BYTES      = 6'd20;
	localparam logic [7:0] TCP_OFFSET_MASK    = 8'hF0;
	localparam logic [7:0] PROTO_TCP          = 8'd6;
	localparam logic [3:0] IP_VERSION_4       = 4'd4;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic [15:0] packet_length;
		logic        last_byte;
	} frame_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [7:0]  ip_protocol;
		logic        last_of_run;
	} result_item_t;

	typedef struct packed {
		logic [1:0]   count;
		result_item_t res_a;
		result_item_t res_b;
	} step_out_t;

	function automatic logic [4:0] link_bytes(input logic [1:0] link);
		case (link)
			LINK_LOOPBACK: return LOOPBACK_HDR_BYTES;
			LINK_ETHERNET: return ETHERNET_HDR_BYTES;
			default:       return 5'd0;
		endcase
	endfunction

endpackage

>>> src/ithp_parse.sv
// ----------------------------------------------------------------------------
// Header parser step
// Holds the per-frame capture state and works out the results of one byte.
// ----------------------------------------------------------------------------
module ithp_parse #(
	parameter int MAX_FRAME_LENGTH = 65535
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_data,
	input  ithp_pkg::frame_item_t item,
	input  logic                  fire,
	output ithp_pkg::step_out_t   step
);

	localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_LENGTH);

	logic [1:0]  link_layer_q;
	logic [15:0] byte_offset_q;
	logic [15:0] frame_length_q;
	logic [5:0]  ip_hl_q;
	logic [5:0]  tcp_hl_q;
	logic [7:0]  protocol_q;
	logic [31:0] source_q;
	logic [31:0] destination_q;
	logic [15:0] source_port_q;
	logic [15:0] destination_port_q;
	logic        tcp_mode_q;
	logic        dropped_q;

	logic [15:0] flen_c, off_c, off_n;
	logic [5:0]  ihl_c, ihl_n, thl_c, thl_n;
	logic [7:0]  proto_n;
	logic [31:0] sa_n, da_n;
	logic [15:0] sp_n, dp_n;
	logic        tcp_c, tcp_n, drop_c, drop_n;
	logic [4:0]  l2;
	logic [15:0] l2_w, rel, l4;
	logic [5:0]  ihl_b, thl_b;
	logic [7:0]  masked_b;
	logic        tcp_v, pay;
	logic [16:0] seen, need;
	logic        ok;
	ithp_pkg::result_item_t pay_res, sum_res;

	always_comb begin
		flen_c = item.first_byte ?
			((item.packet_length > MAX_LEN) ? MAX_LEN : item.packet_length) : frame_length_q;
		off_c   = item.first_byte ? 16'd0 : byte_offset_q;
		ihl_c   = item.first_byte ? 6'd0 : ip_hl_q;
		thl_c   = item.first_byte ? 6'd0 : tcp_hl_q;
		tcp_c   = item.first_byte ? 1'b0 : tcp_mode_q;
		drop_c  = item.first_byte ? 1'b0 : dropped_q;
		proto_n = item.first_byte ? 8'd0 : protocol_q;
		sa_n    = item.first_byte ? 32'd0 : source_q;
		da_n    = item.first_byte ? 32'd0 : destination_q;
		sp_n    = item.first_byte ? 16'd0 : source_port_q;
		dp_n    = item.first_byte ? 16'd0 : destination_port_q;
		ihl_n   = ihl_c;
		thl_n   = thl_c;
		tcp_n   = tcp_c;
		drop_n  = drop_c;
		l2      = ithp_pkg::link_bytes(link_layer_q);
		l2_w    = {11'd0, l2};
		rel     = off_c - l2_w;
		l4      = rel - {10'd0, ihl_c};
		ihl_b   = {item.data_byte[3:0], 2'b00};
		masked_b = item.data_byte & ithp_pkg::TCP_OFFSET_MASK;
		thl_b   = {masked_b[7:4], 2'b00};
		tcp_v   = tcp_c;
		pay     = 1'b0;

		if (!drop_c && (off_c < flen_c) && (off_c >= l2_w)) begin
			if (rel == 16'd0) begin
				if ((flen_c < l2_w + {10'd0, ithp_pkg::MIN_HDR_BYTES}) ||
				    (item.data_byte[7:4] != ithp_pkg::IP_VERSION_4) ||
				    (ihl_b < ithp_pkg::MIN_HDR_BYTES) ||
				    (flen_c < l2_w + {10'd0, ihl_b})) begin
					drop_n = 1'b1;
				end else begin
					ihl_n = ihl_b;
				end
			end else if (ihl_c == 6'd0) begin
				drop_n = 1'b1;
			end else if (rel < {10'd0, ihl_c}) begin
				if (rel == 16'd9) begin
					proto_n = item.data_byte;
				end else if (rel >= 16'd12 && rel < 16'd16) begin
					sa_n = {sa_n[23:0], item.data_byte};
				end else if (rel >= 16'd16 && rel < 16'd20) begin
					da_n = {da_n[23:0], item.data_byte};
				end
			end else begin
				if (l4 == 16'd0) begin
					tcp_v = (proto_n == ithp_pkg::PROTO_TCP) &&
						(flen_c >= l2_w + {10'd0, ihl_c} + {10'd0, ithp_pkg::MIN_HDR_BYTES});
				end
				tcp_n = tcp_v;
				if (!tcp_v) begin
					pay = 1'b1;
				end else begin
					if (l4 < 16'd2) begin
						sp_n = {sp_n[7:0], item.data_byte};
					end else if (l4 < 16'd4) begin
						dp_n = {dp_n[7:0], item.data_byte};
					end else if (l4 == 16'd12) begin
						if ((thl_b < ithp_pkg::MIN_HDR_BYTES) ||
						    (flen_c < l2_w + {10'd0, ihl_c} + {10'd0, thl_b})) begin
							drop_n = 1'b1;
						end else begin
							thl_n = thl_b;
						end
					end
					pay = (l4 >= 16'd20) && (l4 >= {10'd0, thl_c});
				end
			end
		end

		off_n = (off_c == 16'hFFFF) ? off_c : off_c + 16'd1;

		seen = {1'b0, off_c} + 17'd1;
		need = {12'd0, l2} + {11'd0, ihl_n};
		if (tcp_n) begin
			need = need + ((thl_n > ithp_pkg::MIN_HDR_BYTES) ?
				{11'd0, thl_n} : {11'd0, ithp_pkg::MIN_HDR_BYTES});
		end
		ok = !drop_n && (ihl_n != 6'd0) && (seen >= need);

		pay_res              = '0;
		pay_res.kind         = ithp_pkg::KIND_PAYLOAD;
		pay_res.payload_byte = item.data_byte;
		pay_res.last_of_run  = !item.last_byte;

		sum_res             = '0;
		sum_res.last_of_run = 1'b1;
		if (ok) begin
			sum_res.kind                = ithp_pkg::KIND_ACCEPT;
			sum_res.source_address      = sa_n;
			sum_res.destination_address = da_n;
			sum_res.source_port         = tcp_n ? sp_n : 16'd0;
			sum_res.destination_port    = tcp_n ? dp_n : 16'd0;
			sum_res.ip_protocol         = proto_n;
		end else begin
			sum_res.kind = ithp_pkg::KIND_DROP;
		end

		step.count = {1'b0, pay} + {1'b0, item.last_byte};
		step.res_a = pay ? pay_res : sum_res;
		step.res_b = sum_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_layer_q <= ithp_pkg::LINK_ETHERNET;
		end else if (cfg_valid) begin
			link_layer_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q      <= '0;
			frame_length_q     <= '0;
			ip_hl_q            <= '0;
			tcp_hl_q           <= '0;
			protocol_q         <= '0;
			source_q           <= '0;
			destination_q      <= '0;
			source_port_q      <= '0;
			destination_port_q <= '0;
			tcp_mode_q         <= 1'b0;
			dropped_q          <= 1'b0;
		end else if (fire) begin
			byte_offset_q      <= off_n;
			frame_length_q     <= flen_c;
			ip_hl_q            <= ihl_n;
			tcp_hl_q           <= thl_n;
			protocol_q         <= proto_n;
			source_q           <= sa_n;
			destination_q      <= da_n;
			source_port_q      <= sp_n;
			destination_port_q <= dp_n;
			tcp_mode_q         <= tcp_n;
			dropped_q          <= drop_n | item.last_byte;
		end
	end

	a_last_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.last_byte |=> dropped_q)
		else $error("Frame still open after its last byte.");

	a_first_restarts_offset: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.first_byte |=> byte_offset_q == 16'd1)
		else $error("Byte offset did not restart on a first byte.");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step.count == 2'd2 |-> step.res_a.kind == ithp_pkg::KIND_PAYLOAD &&
			step.res_b.kind != ithp_pkg::KIND_PAYLOAD)
		else $error("Two results out of order.");

endmodule

>>> src/ithp_res_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue that takes up to two results a cycle and gives out one while out_stall is low.
// ----------------------------------------------------------------------------
module ithp_res_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_count,
	input  ithp_pkg::result_item_t item_a,
	input  ithp_pkg::result_item_t item_b,
	output logic                   room_for_two,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ithp_pkg::result_item_t out_item
);

	localparam int DEPTH = 4;
	localparam int PW = $clog2(DEPTH);

	ithp_pkg::result_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          pop;

	assign out_valid    = (count_q != '0);
	assign out_item     = mem_q[rd_ptr_q];
	assign pop          = out_valid && !out_stall;
	assign room_for_two = (count_q <= (PW+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= item_a;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= item_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_count);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + (PW+1)'(push_count) - (PW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_count != 2'd0 |-> count_q <= (PW+1)'(DEPTH - 2))
		else $error("Result queue written without room.");

endmodule

>>> src/ipv4_tcp_header_parser.sv
// ----------------------------------------------------------------------------
// IPv4/TCP header parser
// Byte-serial frame parser that emits payload bytes and a frame summary.
// ----------------------------------------------------------------------------
// Frame bytes arrive on the frame channel (frame_valid, frame_stall,
// frame_item), one request per byte; first_byte opens a frame and carries its
// declared length, last_byte closes it. Results leave on the result channel
// (result_valid, result_stall, result_item): a payload byte for each byte
// past the IP header and, for TCP, the TCP header, and an accept or drop
// summary on the last byte. The link type register is written through
// cfg_valid, cfg_ready and cfg_data and is always ready.
// A byte accepted into an input register is parsed there; its results enter
// a four-entry result queue once the queue has room for two of them, and the
// receiver takes them from the head of the queue.
// One byte is accepted per cycle while frame_stall is low; a last byte that is
// also payload gives two results, the payload byte and then the summary.
// Reset clears all frame state, empties the queue and sets the link type to
// Ethernet. When the receiver stalls, the queue fills and frame_stall rises
// once fewer than two entries are free and a byte is held.
// ----------------------------------------------------------------------------
module ipv4_tcp_header_parser #(
	parameter int MAX_FRAME_LENGTH = 65535
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_data,
	input  logic                   frame_valid,
	output logic                   frame_stall,
	input  ithp_pkg::frame_item_t  frame_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output ithp_pkg::result_item_t result_item
);

	ithp_pkg::frame_item_t item_s1;
	logic                  valid_s1;
	logic                  room_for_two;
	logic                  fire;
	logic                  take;
	ithp_pkg::step_out_t   step;

	assign cfg_ready   = 1'b1;
	assign fire        = valid_s1 && room_for_two;
	assign frame_stall = valid_s1 && !room_for_two;
	assign take        = frame_valid && !frame_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= frame_item;
		end
	end

	ithp_parse #(
		.MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.item     (item_s1),
		.fire     (fire),
		.step     (step)
	);

	ithp_res_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_count  (fire ? step.count : 2'd0),
		.item_a      (step.res_a),
		.item_b      (step.res_b),
		.room_for_two(room_for_two),
		.out_valid   (result_valid),
		.out_stall   (result_stall),
		.out_item    (result_item)
	);

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("Held byte lost while waiting for the result queue.");

	a_take_loads_stage: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("Accepted byte did not reach the input register.");

endmodule
